[design/ddts_pkg.sv]
// ----------------------------------------------------------------------------
// ddts_pkg: shared types and constants of the drift diffusion trial step
// Widths, configuration register indexes, the register bank struct and the
// request opcodes used by the channels, the register bank and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ddts_pkg;

    // Default fraction bits of the position format
    localparam int FRAC_BITS_DEF = 24;

    // Data and register port widths
    localparam int DATA_W    = 32;
    localparam int BOUND_W   = 31;
    localparam int CFG_NUM   = 8;
    localparam int CFG_IDX_W = $clog2(CFG_NUM);
    localparam int RAMP_W    = 48;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DRIFT_STEP     = 3'd0,
        REG_BOUND          = 3'd1,
        REG_PULSE_GAIN_ONE = 3'd2,
        REG_PULSE_GAIN_TWO = 3'd3,
        REG_DECAY_ONE      = 3'd4,
        REG_DECAY_TWO      = 3'd5,
        REG_RAMP_ONE       = 3'd6,
        REG_RAMP_TWO       = 3'd7
    } cfg_idx_t;

    // Request opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register bank contents
    typedef struct packed {
        logic signed [DATA_W-1:0]  drift_step;
        logic        [BOUND_W-1:0] bound;
        logic signed [DATA_W-1:0]  pulse_gain_one;
        logic signed [DATA_W-1:0]  pulse_gain_two;
        logic        [DATA_W-1:0]  decay_one;
        logic        [DATA_W-1:0]  decay_two;
        logic        [DATA_W-1:0]  ramp_one;
        logic        [DATA_W-1:0]  ramp_two;
    } cfg_t;

endpackage

`default_nettype wire

[design/ddts_req_if.sv]
// ----------------------------------------------------------------------------
// ddts_req_if: request channel of the drift diffusion trial step
// Valid/ready channel carrying the opcode, the process signs and the noise.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddts_req_if;
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic                              sign_one;
    logic                              sign_two;
    logic signed [ddts_pkg::DATA_W-1:0] noise_step;

    modport source (
        output valid, opcode, sign_one, sign_two, noise_step,
        input  ready
    );

    modport sink (
        input  valid, opcode, sign_one, sign_two, noise_step,
        output ready
    );
endinterface

`default_nettype wire

[design/ddts_rsp_if.sv]
// ----------------------------------------------------------------------------
// ddts_rsp_if: result channel of the drift diffusion trial step
// Valid/ready channel carrying trial status, decision, reaction time, position.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddts_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              done_res;
    logic signed [1:0]                 decision;
    logic        [ddts_pkg::DATA_W-1:0] rt_steps;
    logic signed [ddts_pkg::DATA_W-1:0] position;

    modport source (
        output valid, done_res, decision, rt_steps, position,
        input  ready
    );

    modport sink (
        input  valid, done_res, decision, rt_steps, position,
        output ready
    );
endinterface

`default_nettype wire

[design/ddts_cfg.sv]
// ----------------------------------------------------------------------------
// ddts_cfg: configuration register bank
// Eight write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ddts_cfg #(
    parameter int FRAC_BITS = ddts_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [ddts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ddts_pkg::DATA_W-1:0]      cfg_data,
    output ddts_pkg::cfg_t                        cfg
);

    ddts_pkg::cfg_t cfg_reg;

    // Load the addressed register; bound resets to one in the position format
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drift_step     <= '0;
            cfg_reg.bound          <= ddts_pkg::BOUND_W'(1) << FRAC_BITS;
            cfg_reg.pulse_gain_one <= '0;
            cfg_reg.pulse_gain_two <= '0;
            cfg_reg.decay_one      <= '0;
            cfg_reg.decay_two      <= '0;
            cfg_reg.ramp_one       <= '0;
            cfg_reg.ramp_two       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (ddts_pkg::cfg_idx_t'(cfg_index))
                ddts_pkg::REG_DRIFT_STEP:     cfg_reg.drift_step     <= cfg_data;
                ddts_pkg::REG_BOUND:
                    cfg_reg.bound <= cfg_data[ddts_pkg::BOUND_W-1:0];
                ddts_pkg::REG_PULSE_GAIN_ONE: cfg_reg.pulse_gain_one <= cfg_data;
                ddts_pkg::REG_PULSE_GAIN_TWO: cfg_reg.pulse_gain_two <= cfg_data;
                ddts_pkg::REG_DECAY_ONE:      cfg_reg.decay_one      <= cfg_data;
                ddts_pkg::REG_DECAY_TWO:      cfg_reg.decay_two      <= cfg_data;
                ddts_pkg::REG_RAMP_ONE:       cfg_reg.ramp_one       <= cfg_data;
                ddts_pkg::REG_RAMP_TWO:       cfg_reg.ramp_two       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[design/ddts_mul.sv]
// ----------------------------------------------------------------------------
// ddts_mul: shared signed multiplier
// One 33 x 33 signed multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module ddts_mul (
    input  wire logic                                  clk,
    input  wire logic signed [ddts_pkg::MUL_W-1:0]     mul_a,
    input  wire logic signed [ddts_pkg::MUL_W-1:0]     mul_b,
    output logic signed      [ddts_pkg::PROD_W-1:0]    prod
);

    logic signed [ddts_pkg::PROD_W-1:0] prod_reg;

    // Register the product
    always_ff @(posedge clk)
    begin
        prod_reg <= ddts_pkg::PROD_W'(mul_a) * ddts_pkg::PROD_W'(mul_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[design/drift_diffusion_trial_step_top.sv]
// ----------------------------------------------------------------------------
// drift_diffusion_trial_step_top: one Euler step of a two-boundary diffusion
// trial per tick request, with two decaying pulse drifts and pre-scaled noise.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration is written through cfg_we / cfg_index / cfg_data while the
//   block is idle. Requests arrive on req (valid/ready): a start request
//   clears the trial, a tick request advances it by one step. Every request
//   gives exactly one result on rsp (valid/ready).
// Sequencing:
//   A start request, or a tick after the trial has finished, goes straight
//   to loading the result register, which raises rsp.valid. A running tick
//   first forms eight products through the single shared 33 x 33 multiplier,
//   then closes the step, then loads the result register.
//   req.ready is high only while the sequencer is idle, so a new request is
//   taken only once the result of the last one has been loaded.
// Reset:
//   rst_n clears the trial to its finished state with the position at zero
//   and a step count of one; bound resets to 1.0 and the other registers to 0.
// Stalls:
//   The result register holds its value until rsp.ready; the next request is
//   still accepted, and the sequencer waits to load its result until the
//   register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module drift_diffusion_trial_step_top #(
    parameter int FRAC_BITS = ddts_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [ddts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ddts_pkg::DATA_W-1:0]      cfg_data,
    ddts_req_if.sink                              req,
    ddts_rsp_if.source                            rsp
);

    localparam int DW    = ddts_pkg::DATA_W;
    localparam int MW    = ddts_pkg::MUL_W;
    localparam int PW    = ddts_pkg::PROD_W;
    localparam int RW    = ddts_pkg::RAMP_W;
    localparam int BW    = RW + 1;      // 2^32 - ramp, signed
    localparam int HW    = 49;          // p * high part of (2^32 - ramp)
    localparam int QW    = HW + 1;      // full pulse term before saturation
    localparam int SUM_W = 36;          // running sum of one step

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        STEP_G1  = 4'd0,
        STEP_G2  = 4'd1,
        STEP_LO1 = 4'd2,
        STEP_HI1 = 4'd3,
        STEP_LO2 = 4'd4,
        STEP_HI2 = 4'd5,
        STEP_E1  = 4'd6,
        STEP_E2  = 4'd7,
        STEP_FIN = 4'd8
    } step_t;

    // Saturate a pulse term to signed 32 bits
    function automatic logic signed [DW-1:0] sat_q(input logic signed [QW-1:0] v);
        logic signed [QW-1:0] hi_lim;
        logic signed [QW-1:0] lo_lim;
        hi_lim = QW'(32'sh7FFF_FFFF);
        lo_lim = -QW'(64'sh0000_0000_8000_0000);
        if (v > hi_lim)
            return {1'b0, {(DW-1){1'b1}}};
        else if (v < lo_lim)
            return {1'b1, {(DW-1){1'b0}}};
        else
            return v[DW-1:0];
    endfunction

    // Saturate the step sum to signed 32 bits
    function automatic logic signed [DW-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        if (v[SUM_W-1:DW-1] != {(SUM_W-DW+1){v[SUM_W-1]}})
            return v[SUM_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        else
            return v[DW-1:0];
    endfunction

    ddts_pkg::cfg_t cfg;

    state_t              state_reg;
    step_t               step_reg;
    logic signed [DW-1:0] acc_reg;
    logic        [DW-1:0] env1_reg;
    logic        [DW-1:0] env2_reg;
    logic        [RW-1:0] ramp1_reg;
    logic        [RW-1:0] ramp2_reg;
    logic        [DW-1:0] count_reg;
    logic                 fin_reg;
    logic                 neg1_reg;
    logic                 neg2_reg;
    logic signed [DW-1:0] p1_reg;
    logic signed [DW-1:0] p2_reg;
    logic signed [DW:0]   lo_reg;
    logic signed [SUM_W-1:0] sum_reg;

    logic                 out_valid_reg;
    logic                 out_done_reg;
    logic signed [1:0]    out_dec_reg;
    logic        [DW-1:0] out_rt_reg;
    logic signed [DW-1:0] out_pos_reg;

    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] prod;

    logic signed [BW-1:0] b1;
    logic signed [BW-1:0] b2;
    logic signed [HW-1:0] hi_part;
    logic signed [QW-1:0] q_full;
    logic signed [DW-1:0] q_sat;
    logic signed [DW:0]   q_term;
    logic                 q_neg;
    logic signed [SUM_W-1:0] sum_q;
    logic signed [DW-1:0] acc_new;
    logic signed [DW:0]   bound_s;
    logic                 hit;
    logic        [RW:0]   ramp1_sum;
    logic        [RW:0]   ramp2_sum;
    logic        [RW-1:0] ramp1_next;
    logic        [RW-1:0] ramp2_next;
    logic        [DW-1:0] count_next;
    logic                 accept;
    logic                 out_free;
    logic                 emit_load;

    // Register bank
    ddts_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Shared multiplier
    ddts_mul u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    // Ramp complements 2^32 - ramp, split into a low word and a signed high part
    assign b1 = BW'(64'sh1_0000_0000) - $signed({1'b0, ramp1_reg});
    assign b2 = BW'(64'sh1_0000_0000) - $signed({1'b0, ramp2_reg});

    // Select multiplier operands for the current step
    always_comb
    begin
        unique case (step_reg)
            STEP_G1:
            begin
                mul_a = MW'(cfg.pulse_gain_one);
                mul_b = $signed({1'b0, env1_reg});
            end
            STEP_G2:
            begin
                mul_a = MW'(cfg.pulse_gain_two);
                mul_b = $signed({1'b0, env2_reg});
            end
            STEP_LO1:
            begin
                mul_a = MW'(p1_reg);
                mul_b = $signed({1'b0, b1[DW-1:0]});
            end
            STEP_HI1:
            begin
                mul_a = MW'(p1_reg);
                mul_b = MW'($signed(b1[BW-1:DW]));
            end
            STEP_LO2:
            begin
                mul_a = MW'(p2_reg);
                mul_b = $signed({1'b0, b2[DW-1:0]});
            end
            STEP_HI2:
            begin
                mul_a = MW'(p2_reg);
                mul_b = MW'($signed(b2[BW-1:DW]));
            end
            STEP_E1:
            begin
                mul_a = $signed({1'b0, env1_reg});
                mul_b = $signed({1'b0, cfg.decay_one});
            end
            STEP_E2:
            begin
                mul_a = $signed({1'b0, env2_reg});
                mul_b = $signed({1'b0, cfg.decay_two});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Combine high and low partial products into one signed pulse term
    assign hi_part = prod[HW-1:0];
    assign q_full  = QW'(hi_part) + QW'(lo_reg);
    assign q_sat   = sat_q(q_full);
    assign q_neg   = (step_reg == STEP_LO2) ? neg1_reg : neg2_reg;
    assign q_term  = q_neg ? -(DW+1)'(q_sat) : (DW+1)'(q_sat);
    assign sum_q   = sum_reg + SUM_W'(q_term);

    // Close the step: saturate, check both boundaries, advance ramps and count
    assign acc_new    = sat_sum(sum_reg);
    assign bound_s    = $signed({2'b00, cfg.bound});
    assign hit        = ((DW+1)'(acc_new) >= bound_s) || ((DW+1)'(acc_new) <= -bound_s);
    assign ramp1_sum  = {1'b0, ramp1_reg} + (RW+1)'(cfg.ramp_one);
    assign ramp2_sum  = {1'b0, ramp2_reg} + (RW+1)'(cfg.ramp_two);
    assign ramp1_next = ramp1_sum[RW] ? {RW{1'b1}} : ramp1_sum[RW-1:0];
    assign ramp2_next = ramp2_sum[RW] ? {RW{1'b1}} : ramp2_sum[RW-1:0];
    assign count_next = (&count_reg) ? count_reg : count_reg + DW'(1);

    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign emit_load = (state_reg == S_EMIT) && out_free;

    // Sequencer, trial state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_G1;
            acc_reg       <= '0;
            env1_reg      <= '0;
            env2_reg      <= '0;
            ramp1_reg     <= '0;
            ramp2_reg     <= '0;
            count_reg     <= DW'(1);
            fin_reg       <= 1'b1;
            neg1_reg      <= 1'b0;
            neg2_reg      <= 1'b0;
            p1_reg        <= '0;
            p2_reg        <= '0;
            lo_reg        <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_done_reg  <= 1'b0;
            out_dec_reg   <= '0;
            out_rt_reg    <= '0;
            out_pos_reg   <= '0;
        end
        else
        begin
            // Drop the result once taken, unless a new one is loaded now
            if (rsp.ready && !emit_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.opcode == ddts_pkg::OP_START)
                        begin
                            acc_reg   <= '0;
                            env1_reg  <= cfg.decay_one;
                            env2_reg  <= cfg.decay_two;
                            ramp1_reg <= RW'(cfg.ramp_one);
                            ramp2_reg <= RW'(cfg.ramp_two);
                            count_reg <= DW'(1);
                            neg1_reg  <= req.sign_one;
                            neg2_reg  <= req.sign_two;
                            fin_reg   <= (cfg.bound == '0);
                            state_reg <= S_EMIT;
                        end
                        else if (fin_reg)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            sum_reg   <= SUM_W'(acc_reg) + SUM_W'(cfg.drift_step)
                                         + SUM_W'(req.noise_step);
                            step_reg  <= STEP_G1;
                            state_reg <= S_RUN;
                        end
                    end
                end

                S_RUN:
                begin
                    unique case (step_reg)
                        STEP_G2:  p1_reg   <= prod[2*DW-1:DW];
                        STEP_LO1: p2_reg   <= prod[2*DW-1:DW];
                        STEP_HI1: lo_reg   <= prod[2*DW:DW];
                        STEP_LO2: sum_reg  <= sum_q;
                        STEP_HI2: lo_reg   <= prod[2*DW:DW];
                        STEP_E1:  sum_reg  <= sum_q;
                        STEP_E2:  env1_reg <= prod[2*DW-1:DW];
                        STEP_FIN:
                        begin
                            env2_reg  <= prod[2*DW-1:DW];
                            acc_reg   <= acc_new;
                            ramp1_reg <= ramp1_next;
                            ramp2_reg <= ramp2_next;
                            count_reg <= count_next;
                            fin_reg   <= hit;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (step_reg == STEP_FIN)
                        state_reg <= S_EMIT;
                    else
                        step_reg <= step_t'(step_reg + 4'd1);
                end

                S_EMIT:
                begin
                    // Hold until the result register is free, then load it
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_done_reg  <= fin_reg;
                        out_rt_reg    <= count_reg;
                        out_pos_reg   <= acc_reg;
                        if (!fin_reg || acc_reg == '0)
                            out_dec_reg <= 2'sb00;
                        else if (acc_reg[DW-1])
                            out_dec_reg <= 2'sb11;
                        else
                            out_dec_reg <= 2'sb01;
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.done_res = out_done_reg;
    assign rsp.decision = out_dec_reg;
    assign rsp.rt_steps = out_rt_reg;
    assign rsp.position = out_pos_reg;

endmodule

`default_nettype wire
